/* src/gbfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared codes, widths and types for the grid breadth-first search block.
// ----------------------------------------------------------------------------
package gbfs_pkg;

	localparam int CFG_W    = 6;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int FUNC_W   = 2;
	localparam int KIND_W   = 2;
	localparam int STAT_W   = 2;
	localparam int POS_W    = 5;
	localparam int LEN_W    = 10;

	localparam logic [CFG_W-1:0] DIM_RESET = 6'd32;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FETCH  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	localparam logic [KIND_W-1:0] KIND_DIRTY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ROBOT = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_DIRT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

	localparam logic [1:0] DIR_RIGHT = 2'd0;
	localparam logic [1:0] DIR_LEFT  = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_UP    = 2'd3;

	typedef struct packed {
		logic [CFG_W-1:0] rows;
		logic [CFG_W-1:0] cols;
	} cfg_regs_t;

endpackage

/* src/grid_bfs_nearest_target_path.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bfs_nearest_target_path
// Grid loader, breadth-first nearest dirty cell search and path fetch.
// Load returns no result. Fetch returns the next path cell, or an empty status.
// Search: a distance clear sweep over all 2^(2*clog2 MAX_DIM) entries and an init
// step, then each visited cell and its in-grid neighbors are read, and the
// path is traced back from the target; a robot outside the grid fails without a sweep.
// Reset clears control state and the robot position; results cannot be stalled.
// ----------------------------------------------------------------------------
module grid_bfs_nearest_target_path #(
	parameter int MAX_DIM = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gbfs_pkg::APB_AW-1:0]  paddr,
	input  logic [gbfs_pkg::APB_DW-1:0]  pwdata,
	output logic [gbfs_pkg::APB_DW-1:0]  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [gbfs_pkg::FUNC_W-1:0]  func,
	input  logic [gbfs_pkg::POS_W-1:0]   cell_row,
	input  logic [gbfs_pkg::POS_W-1:0]   cell_col,
	input  logic [gbfs_pkg::KIND_W-1:0]  cell_kind,
	output logic                         done,
	output logic [gbfs_pkg::STAT_W-1:0]  status,
	output logic [gbfs_pkg::POS_W-1:0]   out_row,
	output logic [gbfs_pkg::POS_W-1:0]   out_col,
	output logic [gbfs_pkg::LEN_W-1:0]   path_length,
	output logic                         last_step
);
	import gbfs_pkg::*;

	cfg_regs_t regs;

	gbfs_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .regs(regs)
	);

	gbfs_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .regs(regs), .start(start), .func(func),
		.cell_row(cell_row), .cell_col(cell_col), .cell_kind(cell_kind),
		.busy(busy), .done(done), .status(status), .out_row(out_row),
		.out_col(out_col), .path_length(path_length), .last_step(last_step)
	);
endmodule

/* src/gbfs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gbfs_ram #(
	parameter int W  = 10,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

/* src/gbfs_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_cfg
// APB register file holding the grid dimensions.
// ----------------------------------------------------------------------------
module gbfs_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gbfs_pkg::APB_AW-1:0] paddr,
	input  logic [gbfs_pkg::APB_DW-1:0] pwdata,
	output logic [gbfs_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output gbfs_pkg::cfg_regs_t        regs
);
	import gbfs_pkg::*;

	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic             wr_en;
	logic             reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
		end else if (wr_en) begin
			if (reg_idx == REG_ROWS) begin
				rows_q <= pwdata[CFG_W-1:0];
			end else begin
				cols_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	assign prdata    = (reg_idx == REG_COLS) ? APB_DW'(cols_q) : APB_DW'(rows_q);
	assign regs.rows = rows_q;
	assign regs.cols = cols_q;
endmodule

/* src/gbfs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfs_ctrl
// Request sequencer: cell loads, breadth-first walk, path trace and fetch.
// ----------------------------------------------------------------------------
module gbfs_ctrl #(
	parameter int MAX_DIM = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gbfs_pkg::cfg_regs_t          regs,
	input  logic                         start,
	input  logic [gbfs_pkg::FUNC_W-1:0]  func,
	input  logic [gbfs_pkg::POS_W-1:0]   cell_row,
	input  logic [gbfs_pkg::POS_W-1:0]   cell_col,
	input  logic [gbfs_pkg::KIND_W-1:0]  cell_kind,
	output logic                         busy,
	output logic                         done,
	output logic [gbfs_pkg::STAT_W-1:0]  status,
	output logic [gbfs_pkg::POS_W-1:0]   out_row,
	output logic [gbfs_pkg::POS_W-1:0]   out_col,
	output logic [gbfs_pkg::LEN_W-1:0]   path_length,
	output logic                         last_step
);
	import gbfs_pkg::*;

	localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW    = 2 * DW;
	localparam int CW    = $clog2(MAX_DIM + 1) + 1;
	localparam int NW    = AW + 1;
	localparam int DEPTH = 1 << AW;
	localparam logic [NW-1:0] UNREACHED = '1;
	localparam logic [CW-1:0] MAXD = CW'(MAX_DIM);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLEAR = 4'd1;
	localparam logic [3:0] S_INIT  = 4'd2;
	localparam logic [3:0] S_POP   = 4'd3;
	localparam logic [3:0] S_POPW  = 4'd4;
	localparam logic [3:0] S_CURD  = 4'd5;
	localparam logic [3:0] S_NB    = 4'd6;
	localparam logic [3:0] S_NBW   = 4'd7;
	localparam logic [3:0] S_TRST  = 4'd8;
	localparam logic [3:0] S_TRNB  = 4'd9;
	localparam logic [3:0] S_TRW   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_FETW  = 4'd12;

	logic [3:0]    state_q;
	logic [1:0]    k_q;
	logic [DW-1:0] cur_row_q, cur_col_q;
	logic [AW-1:0] nb_q, tgt_q, robot_q, clr_q;
	logic [NW-1:0] cur_dist_q, len_q, n_q, head_q, tail_q, ptr_q, cnt_q;

	logic              done_q, last_q;
	logic [STAT_W-1:0] status_q;
	logic [POS_W-1:0]  row_q, col_q;
	logic [LEN_W-1:0]  plen_q;

	logic [CW-1:0]     rows, cols;
	logic              nb_valid;
	logic [DW-1:0]     nb_row, nb_col;
	logic [AW-1:0]     nb_addr;
	logic [DW-1:0]     ld_row, ld_col;
	logic              ld_ok;
	logic              robot_out;

	logic              kind_we, dist_we, fifo_we, path_we;
	logic [AW-1:0]     kind_wa, dist_wa, fifo_wa, path_wa, dist_ra;
	logic [KIND_W-1:0] kind_wd, kind_rd;
	logic [NW-1:0]     dist_wd, dist_rd;
	logic [AW-1:0]     fifo_wd, fifo_rd, path_wd, path_rd;
	logic              nb_take;

	always_comb begin
		rows = CW'(regs.rows);
		cols = CW'(regs.cols);
		if (regs.rows == '0) rows = CW'(1);
		else if (CW'(regs.rows) > MAXD) rows = MAXD;
		if (regs.cols == '0) cols = CW'(1);
		else if (CW'(regs.cols) > MAXD) cols = MAXD;
	end

	always_comb begin
		nb_row   = cur_row_q;
		nb_col   = cur_col_q;
		nb_valid = 1'b0;
		unique case (k_q)
			DIR_RIGHT: begin
				nb_valid = (CW'(cur_col_q) + CW'(1)) < cols;
				nb_col   = cur_col_q + DW'(1);
			end
			DIR_LEFT: begin
				nb_valid = cur_col_q != '0;
				nb_col   = cur_col_q - DW'(1);
			end
			DIR_DOWN: begin
				nb_valid = (CW'(cur_row_q) + CW'(1)) < rows;
				nb_row   = cur_row_q + DW'(1);
			end
			default: begin
				nb_valid = cur_row_q != '0;
				nb_row   = cur_row_q - DW'(1);
			end
		endcase
	end

	assign nb_addr   = {nb_row, nb_col};
	assign ld_ok     = (CW'(cell_row) < MAXD) && (CW'(cell_col) < MAXD);
	assign ld_row    = DW'(cell_row);
	assign ld_col    = DW'(cell_col);
	assign robot_out = (CW'(robot_q[AW-1:DW]) >= rows) || (CW'(robot_q[DW-1:0]) >= cols);
	assign nb_take   = (kind_rd != KIND_WALL) && (dist_rd == UNREACHED);
	assign dist_ra   = (state_q == S_POPW) ? fifo_rd : nb_addr;

	always_comb begin
		kind_we = 1'b0;
		kind_wa = tgt_q;
		kind_wd = KIND_FREE;
		dist_we = 1'b0;
		dist_wa = nb_q;
		dist_wd = cur_dist_q + NW'(1);
		fifo_we = 1'b0;
		fifo_wa = tail_q[AW-1:0];
		fifo_wd = nb_q;
		path_we = 1'b0;
		path_wa = AW'(len_q - NW'(1) - n_q);
		path_wd = {cur_row_q, cur_col_q};
		unique case (state_q)
			S_IDLE: begin
				if (start && func == FUNC_LOAD && ld_ok) begin
					kind_we = 1'b1;
					kind_wa = {ld_row, ld_col};
					kind_wd = (cell_kind == KIND_ROBOT) ? KIND_FREE : cell_kind;
				end
			end
			S_CLEAR: begin
				dist_we = 1'b1;
				dist_wa = clr_q;
				dist_wd = UNREACHED;
			end
			S_INIT: begin
				dist_we = 1'b1;
				dist_wa = robot_q;
				dist_wd = '0;
				fifo_we = 1'b1;
				fifo_wa = '0;
				fifo_wd = robot_q;
			end
			S_NBW: begin
				if (nb_take) begin
					dist_we = 1'b1;
					fifo_we = (kind_rd != KIND_DIRTY) && (tail_q < NW'(DEPTH));
				end
			end
			S_TRST: path_we = 1'b1;
			S_FIN:  kind_we = 1'b1;
			default: ;
		endcase
	end

	gbfs_ram #(.W(KIND_W), .AW(AW)) u_kind (
		.clk(clk), .we(kind_we), .waddr(kind_wa), .wdata(kind_wd),
		.raddr(nb_addr), .rdata(kind_rd)
	);
	gbfs_ram #(.W(NW), .AW(AW)) u_dist (
		.clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
		.raddr(dist_ra), .rdata(dist_rd)
	);
	gbfs_ram #(.W(AW), .AW(AW)) u_fifo (
		.clk(clk), .we(fifo_we), .waddr(fifo_wa), .wdata(fifo_wd),
		.raddr(head_q[AW-1:0]), .rdata(fifo_rd)
	);
	gbfs_ram #(.W(AW), .AW(AW)) u_path (
		.clk(clk), .we(path_we), .waddr(path_wa), .wdata(path_wd),
		.raddr(ptr_q[AW-1:0]), .rdata(path_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			k_q      <= DIR_RIGHT;
			robot_q  <= '0;
			ptr_q    <= '0;
			cnt_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			clr_q    <= '0;
			n_q      <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= STAT_OK;
						row_q    <= '0;
						col_q    <= '0;
						plen_q   <= '0;
						last_q   <= 1'b0;
						case (func)
							FUNC_LOAD: begin
								if (ld_ok && cell_kind == KIND_ROBOT) begin
									robot_q <= {ld_row, ld_col};
								end
							end
							FUNC_SEARCH: begin
								if (robot_out) begin
									status_q <= STAT_NO_DIRT;
									cnt_q    <= '0;
									ptr_q    <= '0;
									done_q   <= 1'b1;
								end else begin
									clr_q   <= '0;
									state_q <= S_CLEAR;
								end
							end
							FUNC_FETCH: begin
								if (ptr_q >= cnt_q) begin
									status_q <= STAT_EMPTY;
									done_q   <= 1'b1;
								end else begin
									ptr_q   <= ptr_q + NW'(1);
									state_q <= S_FETW;
								end
							end
							default: ;
						endcase
					end
				end
				S_FETW: begin
					row_q   <= POS_W'(path_rd[AW-1:DW]);
					col_q   <= POS_W'(path_rd[DW-1:0]);
					last_q  <= ptr_q == cnt_q;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= S_INIT;
				end
				S_INIT: begin
					head_q  <= '0;
					tail_q  <= NW'(1);
					state_q <= S_POP;
				end
				S_POP: begin
					if (head_q == tail_q) begin
						status_q <= STAT_NO_DIRT;
						cnt_q    <= '0;
						ptr_q    <= '0;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						head_q  <= head_q + NW'(1);
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					cur_row_q <= fifo_rd[AW-1:DW];
					cur_col_q <= fifo_rd[DW-1:0];
					state_q   <= S_CURD;
				end
				S_CURD: begin
					cur_dist_q <= dist_rd;
					k_q        <= DIR_RIGHT;
					state_q    <= S_NB;
				end
				S_NB: begin
					if (nb_valid) begin
						nb_q    <= nb_addr;
						state_q <= S_NBW;
					end else if (k_q == DIR_UP) begin
						state_q <= S_POP;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_NBW: begin
					if (nb_take && kind_rd == KIND_DIRTY) begin
						tgt_q      <= nb_q;
						cur_row_q  <= nb_q[AW-1:DW];
						cur_col_q  <= nb_q[DW-1:0];
						len_q      <= cur_dist_q + NW'(1);
						cur_dist_q <= cur_dist_q + NW'(1);
						n_q        <= '0;
						state_q    <= S_TRST;
					end else begin
						if (nb_take && tail_q < NW'(DEPTH)) tail_q <= tail_q + NW'(1);
						if (k_q == DIR_UP) begin
							state_q <= S_POP;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_NB;
						end
					end
				end
				S_TRST: begin
					n_q <= n_q + NW'(1);
					k_q <= DIR_RIGHT;
					if (n_q + NW'(1) == len_q) state_q <= S_FIN;
					else state_q <= S_TRNB;
				end
				S_TRNB: begin
					if (nb_valid) begin
						nb_q    <= nb_addr;
						state_q <= S_TRW;
					end else if (k_q == DIR_UP) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_TRW: begin
					if (dist_rd == cur_dist_q - NW'(1)) begin
						cur_row_q  <= nb_q[AW-1:DW];
						cur_col_q  <= nb_q[DW-1:0];
						cur_dist_q <= cur_dist_q - NW'(1);
						state_q    <= S_TRST;
					end else if (k_q == DIR_UP) begin
						state_q <= S_FIN;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_TRNB;
					end
				end
				S_FIN: begin
					robot_q  <= tgt_q;
					cnt_q    <= len_q;
					ptr_q    <= '0;
					status_q <= STAT_OK;
					row_q    <= POS_W'(tgt_q[AW-1:DW]);
					col_q    <= POS_W'(tgt_q[DW-1:0]);
					plen_q   <= LEN_W'(len_q);
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign out_row     = row_q;
	assign out_col     = col_q;
	assign path_length = plen_q;
	assign last_step   = last_q;
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid breadth-first search block. Grids are
// loaded cell by cell through the request port, searches and path fetches are
// issued, and each result is compared with a behavioral grid search kept in
// the bench. Grid size is changed through the APB port between phases.
// ----------------------------------------------------------------------------
module tb_top;
	import gbfs_pkg::*;

	localparam int DIM   = 32;
	localparam int CELLS = DIM * DIM;

	typedef struct {
		logic [FUNC_W-1:0] fn;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic [KIND_W-1:0] kind;
	} request_t;

	typedef struct {
		logic [STAT_W-1:0] stat;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic [LEN_W-1:0]  len;
		logic              last;
	} answer_t;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;
	logic start, busy, done, last_step;
	logic [FUNC_W-1:0] func;
	logic [POS_W-1:0] cell_row, cell_col, out_row, out_col;
	logic [KIND_W-1:0] cell_kind;
	logic [STAT_W-1:0] status;
	logic [LEN_W-1:0] path_length;

	grid_bfs_nearest_target_path dut (.*);

	request_t request_q[$];
	answer_t  pending_results[$];
	request_t driven;
	int       idle_pct;
	int       errors;

	logic [KIND_W-1:0] grid_kind[CELLS];
	int grid_dist[CELLS];
	int bfs_fifo[CELLS];
	int route[CELLS];
	int robot_pos, route_ptr, route_cnt;
	logic [CFG_W-1:0] rows_reg, cols_reg;

	function automatic int eff_dim(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > DIM) return DIM;
		return v;
	endfunction

	function automatic bit step_to(int idx, int k, int nr, int nc, output int nb);
		int r, c;
		r = idx / DIM;
		c = idx % DIM;
		nb = 0;
		case (k)
			DIR_RIGHT: begin if (c + 1 >= nc) return 0; c++; end
			DIR_LEFT: begin if (c == 0) return 0; c--; end
			DIR_DOWN: begin if (r + 1 >= nr) return 0; r++; end
			default: begin if (r == 0) return 0; r--; end
		endcase
		nb = r * DIM + c;
		return 1;
	endfunction

	function automatic bit find_dirt(int nr, int nc, output int target);
		int head, tail, cur, nb;
		head = 0;
		tail = 0;
		target = 0;
		if (robot_pos / DIM >= nr || robot_pos % DIM >= nc) return 0;
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++)
				grid_dist[r * DIM + c] = -1;
		grid_dist[robot_pos] = 0;
		bfs_fifo[tail++] = robot_pos;
		while (head < tail) begin
			cur = bfs_fifo[head++];
			for (int k = 0; k < 4; k++) begin
				if (!step_to(cur, k, nr, nc, nb)) continue;
				if (grid_kind[nb] == KIND_WALL || grid_dist[nb] != -1) continue;
				grid_dist[nb] = grid_dist[cur] + 1;
				if (grid_kind[nb] == KIND_DIRTY) begin
					target = nb;
					return 1;
				end
				if (tail < CELLS) bfs_fifo[tail++] = nb;
			end
		end
		return 0;
	endfunction

	function automatic void trace_route(int nr, int nc, int target);
		int cur, len, n, nb;
		bit moved;
		cur = target;
		len = grid_dist[target];
		n = 0;
		if (len > CELLS) len = CELLS;
		while (grid_dist[cur] != 0 && n < len) begin
			route[len - 1 - n] = cur;
			n++;
			moved = 0;
			for (int k = 0; k < 4 && !moved; k++)
				if (step_to(cur, k, nr, nc, nb) && grid_dist[nb] == grid_dist[cur] - 1) begin
					cur = nb;
					moved = 1;
				end
			if (!moved) break;
		end
		route_cnt = len;
		route_ptr = 0;
	endfunction

	function automatic void bfs_predict(request_t rq);
		answer_t a;
		int nr, nc, tgt, idx;
		nr = eff_dim(rows_reg);
		nc = eff_dim(cols_reg);
		a = '{STAT_OK, 0, 0, 0, 0};
		idx = rq.row * DIM + rq.col;
		case (rq.fn)
			FUNC_LOAD: begin
				if (rq.kind == KIND_ROBOT) begin
					grid_kind[idx] = KIND_FREE;
					robot_pos = idx;
				end else
					grid_kind[idx] = rq.kind;
			end
			FUNC_SEARCH: begin
				if (!find_dirt(nr, nc, tgt)) begin
					route_cnt = 0;
					route_ptr = 0;
					a.stat = STAT_NO_DIRT;
				end else begin
					trace_route(nr, nc, tgt);
					grid_kind[tgt] = KIND_FREE;
					robot_pos = tgt;
					a.row = tgt / DIM;
					a.col = tgt % DIM;
					a.len = route_cnt;
				end
				pending_results.push_back(a);
			end
			FUNC_FETCH: begin
				if (route_ptr >= route_cnt)
					a.stat = STAT_EMPTY;
				else begin
					a.row = route[route_ptr] / DIM;
					a.col = route[route_ptr] % DIM;
					route_ptr++;
					a.last = (route_ptr == route_cnt);
				end
				pending_results.push_back(a);
			end
			default: ;
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			func <= FUNC_LOAD;
			cell_row <= '0;
			cell_col <= '0;
			cell_kind <= KIND_DIRTY;
		end else begin
			if (start && !busy) bfs_predict(driven);
			if (start && busy) begin
			end else if (request_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				driven = request_q.pop_front();
				start <= 1'b1;
				func <= driven.fn;
				cell_row <= driven.row;
				cell_col <= driven.col;
				cell_kind <= driven.kind;
			end else
				start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d row %0d col %0d", $time,
					status, out_row, out_col);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.stat || out_row !== e.row || out_col !== e.col ||
						path_length !== e.len || last_step !== e.last) begin
					$display({"%0t: expected st %0d r %0d c %0d len %0d last %0d, ",
						"got st %0d r %0d c %0d len %0d last %0d"},
						$time, e.stat, e.row, e.col, e.len, e.last,
						status, out_row, out_col, path_length, last_step);
					errors++;
				end
			end
		end
	end

	task automatic push_req(logic [FUNC_W-1:0] f, int r = 0, int c = 0, int k = 0);
		request_t rq;
		rq.fn = f;
		rq.row = r;
		rq.col = c;
		rq.kind = k;
		request_q.push_back(rq);
	endtask

	task automatic drain();
		wait (request_q.size() == 0);
		@(posedge clk);
		while (start || pending_results.size() != 0 || busy) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic reg_write(logic [APB_AW-1:0] addr, logic [CFG_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (addr == 0) rows_reg = val;
		else cols_reg = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_grid(int nr, int nc);
		drain();
		reg_write(APB_AW'(4 * REG_ROWS), nr);
		reg_write(APB_AW'(4 * REG_COLS), nc);
	endtask

	task automatic fill_grid(int dirt_pct, int wall_pct);
		int nr, nc, v;
		nr = eff_dim(rows_reg);
		nc = eff_dim(cols_reg);
		for (int r = 0; r < nr; r++)
			for (int c = 0; c < nc; c++) begin
				v = $urandom_range(99);
				push_req(FUNC_LOAD, r, c, v < dirt_pct ? KIND_DIRTY :
					v < dirt_pct + wall_pct ? KIND_WALL : KIND_FREE);
			end
		push_req(FUNC_LOAD, $urandom_range(nr - 1), $urandom_range(nc - 1), KIND_ROBOT);
	endtask

	task automatic random_traffic(int n);
		int nr, nc, v;
		nr = eff_dim(rows_reg);
		nc = eff_dim(cols_reg);
		for (int i = 0; i < n; i++) begin
			v = $urandom_range(99);
			if (v < 45) begin
				push_req(FUNC_SEARCH);
				repeat ($urandom_range(nr + nc)) push_req(FUNC_FETCH);
			end else if (v < 80)
				push_req(FUNC_LOAD, $urandom_range(nr - 1), $urandom_range(nc - 1),
					$urandom_range(3));
			else if (v < 90)
				push_req(FUNC_FETCH);
			else
				push_req(FUNC_UNUSED, $urandom_range(31), $urandom_range(31),
					$urandom_range(3));
		end
	endtask

	initial begin
		int sizes[6][2];
		int idles[6];
		errors = 0;
		idle_pct = 0;
		rows_reg = DIM_RESET;
		cols_reg = DIM_RESET;
		robot_pos = 0;
		route_ptr = 0;
		route_cnt = 0;
		foreach (grid_kind[i]) begin
			grid_kind[i] = KIND_DIRTY;
			grid_dist[i] = -1;
		end
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// single cell grid: empty path, failed search, robot on a dirty cell
		set_grid(0, 1);
		push_req(FUNC_FETCH);
		push_req(FUNC_LOAD, 0, 0, KIND_ROBOT);
		push_req(FUNC_SEARCH);
		push_req(FUNC_LOAD, 0, 0, KIND_DIRTY);
		push_req(FUNC_SEARCH);
		push_req(FUNC_FETCH);
		push_req(FUNC_UNUSED, 31, 31, KIND_ROBOT);

		// small walled grid, full path fetch, then a failed search and a fetch of the empty path
		set_grid(3, 4);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++)
				push_req(FUNC_LOAD, r, c, (c == 1 && r < 2) ? KIND_WALL : KIND_FREE);
		push_req(FUNC_LOAD, 0, 0, KIND_ROBOT);
		push_req(FUNC_LOAD, 0, 3, KIND_DIRTY);
		push_req(FUNC_SEARCH);
		repeat (7) push_req(FUNC_FETCH);
		push_req(FUNC_SEARCH);
		push_req(FUNC_FETCH);

		// robot outside the grid in use
		set_grid(2, 2);
		fill_grid(30, 10);
		push_req(FUNC_LOAD, 5, 1, KIND_ROBOT);
		push_req(FUNC_SEARCH);
		push_req(FUNC_FETCH);

		sizes = '{'{2, 3}, '{1, 4}, '{3, 2}, '{1, 5}, '{2, 2}, '{4, 1}};
		idles = '{0, 82, 33, 82, 0, 33};
		for (int p = 0; p < 6; p++) begin
			set_grid(sizes[p][0], sizes[p][1]);
			idle_pct = idles[p];
			fill_grid(15, 20);
			random_traffic(3);
		end

		// one row grid, columns written above range
		set_grid(1, 63);
		idle_pct = 0;
		fill_grid(1, 10);
		push_req(FUNC_LOAD, 0, 31, KIND_DIRTY);
		push_req(FUNC_LOAD, 0, 0, KIND_ROBOT);
		repeat (2) begin
			push_req(FUNC_SEARCH);
			repeat (3) push_req(FUNC_FETCH);
		end
		push_req(FUNC_LOAD, 0, 31, KIND_WALL);
		push_req(FUNC_SEARCH);

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#400ms;
		$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
src/gbfs_pkg.sv
src/gbfs_ram.sv
src/gbfs_cfg.sv
src/gbfs_ctrl.sv
src/grid_bfs_nearest_target_path.sv
test/tb_top.sv
